// ----- hdl/hml_pkg.sv -----
// ----------------------------------------------------------------------------
// hml_pkg
// Shared constants, types and Morse code tables for the hex Morse LED keyer.
// ----------------------------------------------------------------------------
package hml_pkg;

    localparam int DIGIT_COUNT = 4;
    localparam int DIGIT_IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam int VALUE_W     = 16;
    localparam int HALF_W      = 24;
    localparam int GAP_W       = 25;
    localparam int ELAPSED_W   = 27;
    localparam int CFG_DATA_W  = 25;
    localparam int CFG_IDX_W   = 1;
    localparam int EXT_W       = 32;

    localparam logic [1:0] PH_IDLE      = 2'd0;
    localparam logic [1:0] PH_MARK      = 2'd1;
    localparam logic [1:0] PH_ELEM_GAP  = 2'd2;
    localparam logic [1:0] PH_DIGIT_GAP = 2'd3;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_UNIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_GAP = 1'b1;

    localparam logic [HALF_W-1:0] HALF_UNIT_RST = 24'd500;
    localparam logic [GAP_W-1:0]  DIGIT_GAP_RST = 25'd1000;

    typedef logic [2:0] t_len;
    typedef logic [3:0] t_digit;

    typedef struct packed {
        logic                 done;
        logic [ELAPSED_W-1:0] elapsed;
    } t_timer_res;

    // number of elements in the code of one hex digit
    function automatic t_len code_len(input t_digit d);
        t_len len;
        case (d)
            4'hA:    len = 3'd2;
            4'hB:    len = 3'd4;
            4'hC:    len = 3'd4;
            4'hD:    len = 3'd3;
            4'hE:    len = 3'd1;
            4'hF:    len = 3'd4;
            default: len = 3'd5;
        endcase
        return len;
    endfunction

    // element pattern, first element at bit len-1, 1 = dash
    function automatic logic [7:0] code_bits(input t_digit d);
        logic [7:0] b;
        case (d)
            4'h0:    b = 8'h1F;
            4'h1:    b = 8'h0F;
            4'h2:    b = 8'h07;
            4'h3:    b = 8'h03;
            4'h4:    b = 8'h01;
            4'h5:    b = 8'h00;
            4'h6:    b = 8'h10;
            4'h7:    b = 8'h18;
            4'h8:    b = 8'h1C;
            4'h9:    b = 8'h1E;
            4'hA:    b = 8'h01;
            4'hB:    b = 8'h08;
            4'hC:    b = 8'h0A;
            4'hD:    b = 8'h04;
            4'hE:    b = 8'h00;
            default: b = 8'h02;
        endcase
        return b;
    endfunction

    // digit idx counted from the most significant, zero above the held bits
    function automatic t_digit digit_sel(input logic [VALUE_W-1:0] value,
                                         input logic [DIGIT_IDX_W-1:0] idx);
        logic [EXT_W-1:0] ext;
        logic [4:0]       sh;
        ext = EXT_W'(value);
        sh  = 5'(4 * (DIGIT_COUNT - 1) - 4 * int'(idx));
        return ext[sh +: 4];
    endfunction

    function automatic logic is_dash(input t_digit d, input logic [2:0] elem);
        t_len       len;
        logic [2:0] pos;
        logic [7:0] bits;
        len  = code_len(d);
        bits = code_bits(d);
        pos  = (elem < len) ? 3'(len - 3'd1 - elem) : 3'd0;
        return bits[pos];
    endfunction

endpackage

// ----- hdl/hex_morse_led_keyer.sv -----
// ----------------------------------------------------------------------------
// hex_morse_led_keyer
// Keys the four hex digits of a 16-bit value on an LED in Morse code.
// ----------------------------------------------------------------------------
// input words carry an opcode: tick advances the keying timer by one, load
// takes i_value and restarts keying at the most significant digit in a mark.
// every input word gives exactly one output word with the LED level, the
// keying phase and the digit position after that word.
// o_valid is registered: a word passes the input register, then the state
// update and result register, and waits in the input register while the
// result register is held. one word is accepted every cycle while o_stall
// is low; the rate is set by the state update loop.
// o_stall rises only when the input register is full and the result register
// is held by i_stall, so one more word is taken in behind a waiting result.
// half_unit and digit_gap are written on the config port, by the user only while idle; the block does not enforce it.
// synchronous reset clears both stages, goes idle and restores the register
// defaults (half_unit 500, digit_gap 1000).
// ----------------------------------------------------------------------------
module hex_morse_led_keyer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_opcode,
    input  logic [hml_pkg::VALUE_W-1:0]      i_value,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic                             o_led_on,
    output logic [1:0]                       o_phase,
    output logic [1:0]                       o_digit_position,
    input  logic                             i_cfg_we,
    input  logic [hml_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [hml_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int DW = hml_pkg::DIGIT_IDX_W;
    localparam int EW = hml_pkg::ELAPSED_W;

    logic [hml_pkg::HALF_W-1:0]  r_half_unit;
    logic [hml_pkg::GAP_W-1:0]   r_digit_gap;

    logic                        r_in_valid;
    logic                        r_in_opcode;
    logic [hml_pkg::VALUE_W-1:0] r_in_value;

    logic [hml_pkg::VALUE_W-1:0] r_held,  n_held;
    logic [DW-1:0]               r_digit, n_digit;
    logic [2:0]                  r_elem,  n_elem;
    logic [1:0]                  r_phase, n_phase;
    logic [EW-1:0]               r_elapsed, n_elapsed;

    logic                        r_out_valid;
    logic                        r_led_on;
    logic [1:0]                  r_out_phase;
    logic [1:0]                  r_digit_pos;

    logic                        adv;
    logic                        step;
    hml_pkg::t_digit             cur_digit;
    logic                        cur_dash;
    logic [2:0]                  elem_inc;
    hml_pkg::t_timer_res         tmr;

    assign adv     = !r_out_valid || !i_stall;
    assign step    = r_in_valid && adv;
    assign o_stall = r_in_valid && !adv;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_unit <= hml_pkg::HALF_UNIT_RST;
            r_digit_gap <= hml_pkg::DIGIT_GAP_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == hml_pkg::CFG_HALF_UNIT) begin
                r_half_unit <= i_cfg_data[hml_pkg::HALF_W-1:0];
            end
            if (i_cfg_index == hml_pkg::CFG_DIGIT_GAP) begin
                r_digit_gap <= i_cfg_data[hml_pkg::GAP_W-1:0];
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_opcode <= i_opcode;
            r_in_value  <= i_value;
        end
    end

    assign cur_digit = hml_pkg::digit_sel(r_held, r_digit);
    assign cur_dash  = hml_pkg::is_dash(cur_digit, r_elem);
    assign elem_inc  = r_elem + 3'd1;

    hml_timer u_timer (
        .i_phase     (r_phase),
        .i_dash      (cur_dash),
        .i_elapsed   (r_elapsed),
        .i_half_unit (r_half_unit),
        .i_digit_gap (r_digit_gap),
        .o_res       (tmr)
    );

    // keying state update
    always_comb begin
        n_held    = r_held;
        n_digit   = r_digit;
        n_elem    = r_elem;
        n_phase   = r_phase;
        n_elapsed = r_elapsed;
        if (step) begin
            if (r_in_opcode == hml_pkg::OP_LOAD) begin
                n_held    = r_in_value;
                n_digit   = '0;
                n_elem    = 3'd0;
                n_phase   = hml_pkg::PH_MARK;
                n_elapsed = '0;
            end else if (r_phase != hml_pkg::PH_IDLE) begin
                n_elapsed = tmr.elapsed;
                case (r_phase)
                    hml_pkg::PH_MARK: begin
                        if (tmr.done) begin
                            n_phase   = hml_pkg::PH_ELEM_GAP;
                            n_elapsed = '0;
                        end
                    end
                    hml_pkg::PH_ELEM_GAP: begin
                        if (tmr.done) begin
                            n_elem    = elem_inc;
                            n_elapsed = '0;
                            if (elem_inc >= hml_pkg::code_len(cur_digit)) begin
                                n_phase = hml_pkg::PH_DIGIT_GAP;
                            end else begin
                                n_phase = hml_pkg::PH_MARK;
                            end
                        end
                    end
                    hml_pkg::PH_DIGIT_GAP: begin
                        if (tmr.done) begin
                            if (r_digit == DW'(hml_pkg::DIGIT_COUNT - 1)) begin
                                n_digit = '0;
                            end else begin
                                n_digit = r_digit + 1'b1;
                            end
                            n_elem    = 3'd0;
                            n_phase   = hml_pkg::PH_MARK;
                            n_elapsed = '0;
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held    <= '0;
            r_digit   <= '0;
            r_elem    <= 3'd0;
            r_phase   <= hml_pkg::PH_IDLE;
            r_elapsed <= '0;
        end else begin
            r_held    <= n_held;
            r_digit   <= n_digit;
            r_elem    <= n_elem;
            r_phase   <= n_phase;
            r_elapsed <= n_elapsed;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_led_on    <= (n_phase == hml_pkg::PH_MARK);
            r_out_phase <= n_phase;
            r_digit_pos <= (n_phase == hml_pkg::PH_IDLE) ? 2'd0 : 2'(n_digit);
        end
    end

    assign o_valid          = r_out_valid;
    assign o_led_on         = r_led_on;
    assign o_phase          = r_out_phase;
    assign o_digit_position = r_digit_pos;

endmodule

// ----- hdl/hml_timer.sv -----
// ----------------------------------------------------------------------------
// hml_timer
// Saturating elapsed tick count and the end-of-phase compare.
// ----------------------------------------------------------------------------
module hml_timer (
    input  logic [1:0]                     i_phase,
    input  logic                           i_dash,
    input  logic [hml_pkg::ELAPSED_W-1:0]  i_elapsed,
    input  logic [hml_pkg::HALF_W-1:0]     i_half_unit,
    input  logic [hml_pkg::GAP_W-1:0]      i_digit_gap,
    output hml_pkg::t_timer_res            o_res
);

    localparam int EW = hml_pkg::ELAPSED_W;

    logic [EW-1:0]               e_inc;
    logic [EW+1:0]               e_x3;
    logic [hml_pkg::HALF_W+1:0]  h_x4;
    logic                        done;

    assign e_inc = (&i_elapsed) ? i_elapsed : i_elapsed + 1'b1;
    assign e_x3  = {2'b00, e_inc} + {1'b0, e_inc, 1'b0};
    assign h_x4  = {i_half_unit, 2'b00};

    always_comb begin
        case (i_phase)
            hml_pkg::PH_MARK: begin
                if (i_dash) begin
                    done = {2'b00, e_inc} > (EW + 2)'(h_x4);
                end else begin
                    done = e_x3 > (EW + 2)'(h_x4);
                end
            end
            hml_pkg::PH_ELEM_GAP:  done = e_inc > EW'(i_half_unit);
            hml_pkg::PH_DIGIT_GAP: done = e_inc > EW'(i_digit_gap);
            default:               done = 1'b0;
        endcase
    end

    assign o_res.done    = done;
    assign o_res.elapsed = e_inc;

endmodule

// ----- hdl/hml_checker.sv -----
// ----------------------------------------------------------------------------
// hml_checker
// Port-level checks for the hex Morse LED keyer, bound to the top level.
// ----------------------------------------------------------------------------
module hml_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_stall,
    input logic                            o_valid,
    input logic                            i_stall,
    input logic                            o_led_on,
    input logic [1:0]                      o_phase,
    input logic [1:0]                      o_digit_position
);

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_led_on) && $stable(o_phase)
            && $stable(o_digit_position))
        else $error("output word changed while stalled");

    // led lit exactly during a mark
    a_led_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_led_on == (o_phase == hml_pkg::PH_MARK)))
        else $error("led level does not match phase");

    // idle shows digit zero
    a_idle_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_phase == hml_pkg::PH_IDLE |-> o_digit_position == 2'd0)
        else $error("digit position nonzero while idle");

    // input stalls only behind a held output word
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a held output word");

    // reset empties the output stage
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind hex_morse_led_keyer hml_checker u_hml_checker (.*);

// ----- tb/hex_morse_led_keyer_tb.sv -----
// ----------------------------------------------------------------------------
// hex_morse_led_keyer_tb
// Self-checking bench for the hex Morse LED keyer. A model of the keying state
// follows every accepted input word. Each output word is checked against the
// model's LED level, phase and digit position. The run covers random stalls on
// both sides, one long output hold-off, and timing settings from zero to full
// scale.
// ----------------------------------------------------------------------------
module hex_morse_led_keyer_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 60;
    localparam int DRAIN_CYCLES   = 6;

    typedef struct packed {
        logic       led_on;
        logic [1:0] phase;
        logic [1:0] digit_position;
    } t_led_frame;

    class keyer_scoreboard;
        logic [hml_pkg::VALUE_W-1:0]   held;
        int                            digit;
        logic [2:0]                    element;
        logic [1:0]                    phase;
        logic [hml_pkg::ELAPSED_W-1:0] elapsed;
        logic [hml_pkg::HALF_W-1:0]    half_unit;
        logic [hml_pkg::GAP_W-1:0]     digit_gap;
        t_led_frame                    frames_due[$];
        int                            errors;

        function new();
            held      = '0;
            digit     = 0;
            element   = '0;
            phase     = hml_pkg::PH_IDLE;
            elapsed   = '0;
            half_unit = hml_pkg::HALF_UNIT_RST;
            digit_gap = hml_pkg::DIGIT_GAP_RST;
            errors    = 0;
        endfunction

        // leading one marks the length, then 1 = dash, first element highest
        function logic [5:0] morse_code(input logic [3:0] d);
            case (d)
                4'h0: return 6'b111111;
                4'h1: return 6'b101111;
                4'h2: return 6'b100111;
                4'h3: return 6'b100011;
                4'h4: return 6'b100001;
                4'h5: return 6'b100000;
                4'h6: return 6'b110000;
                4'h7: return 6'b111000;
                4'h8: return 6'b111100;
                4'h9: return 6'b111110;
                4'hA: return 6'b000101;
                4'hB: return 6'b011000;
                4'hC: return 6'b011010;
                4'hD: return 6'b001100;
                4'hE: return 6'b000010;
                default: return 6'b010010;
            endcase
        endfunction

        function int morse_len(input logic [5:0] code);
            for (int i = 5; i > 0; i--) begin
                if (code[i]) return i;
            end
            return 0;
        endfunction

        function logic [3:0] digit_now();
            int sh;
            sh = 4 * (hml_pkg::DIGIT_COUNT - 1 - digit);
            if (sh >= hml_pkg::VALUE_W) return 4'h0;
            return held[sh +: 4];
        endfunction

        function bit dash_now();
            logic [5:0] code;
            int         len;
            int         pos;
            code = morse_code(digit_now());
            len  = morse_len(code);
            pos  = (int'(element) < len) ? len - 1 - int'(element) : 0;
            return code[pos];
        endfunction

        function void set_reg(input logic [hml_pkg::CFG_IDX_W-1:0] idx,
                              input logic [hml_pkg::CFG_DATA_W-1:0] data);
            if (idx == hml_pkg::CFG_HALF_UNIT) begin
                half_unit = data[hml_pkg::HALF_W-1:0];
            end else begin
                digit_gap = data[hml_pkg::GAP_W-1:0];
            end
        endfunction

        function void note_word(input logic op, input logic [hml_pkg::VALUE_W-1:0] v);
            logic [63:0] e;
            logic [63:0] h;
            t_led_frame  f;
            if (op == hml_pkg::OP_LOAD) begin
                held    = v;
                digit   = 0;
                element = '0;
                phase   = hml_pkg::PH_MARK;
                elapsed = '0;
            end else if (phase != hml_pkg::PH_IDLE) begin
                if (elapsed != '1) elapsed = elapsed + 1'b1;
                e = 64'(elapsed);
                h = 64'(half_unit);
                if (phase == hml_pkg::PH_MARK) begin
                    if (dash_now() ? (e > 4 * h) : (3 * e > 4 * h)) begin
                        phase   = hml_pkg::PH_ELEM_GAP;
                        elapsed = '0;
                    end
                end else if (phase == hml_pkg::PH_ELEM_GAP) begin
                    if (e > h) begin
                        element = element + 3'd1;
                        elapsed = '0;
                        if (int'(element) >= morse_len(morse_code(digit_now()))) begin
                            phase = hml_pkg::PH_DIGIT_GAP;
                        end else begin
                            phase = hml_pkg::PH_MARK;
                        end
                    end
                end else if (e > 64'(digit_gap)) begin
                    digit   = (digit + 1 >= hml_pkg::DIGIT_COUNT) ? 0 : digit + 1;
                    element = '0;
                    phase   = hml_pkg::PH_MARK;
                    elapsed = '0;
                end
            end
            f.led_on         = (phase == hml_pkg::PH_MARK);
            f.phase          = phase;
            f.digit_position = (phase == hml_pkg::PH_IDLE) ? 2'd0 : 2'(digit);
            frames_due.push_back(f);
        endfunction

        function void check_word(input t_led_frame got);
            t_led_frame want;
            if (frames_due.size() == 0) begin
                $display("%0t: unexpected word: led_on %0d phase %0d digit %0d",
                         $time, got.led_on, got.phase, got.digit_position);
                errors++;
                return;
            end
            want = frames_due.pop_front();
            if (got != want) begin
                $display({"%0t: mismatch: expected led_on %0d phase %0d digit %0d,",
                          " actual led_on %0d phase %0d digit %0d"},
                         $time, want.led_on, want.phase, want.digit_position,
                         got.led_on, got.phase, got.digit_position);
                errors++;
            end
        endfunction
    endclass

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_valid;
    logic                           o_stall;
    logic                           i_opcode;
    logic [hml_pkg::VALUE_W-1:0]    i_value;
    logic                           o_valid;
    logic                           i_stall;
    logic                           o_led_on;
    logic [1:0]                     o_phase;
    logic [1:0]                     o_digit_position;
    logic                           i_cfg_we;
    logic [hml_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [hml_pkg::CFG_DATA_W-1:0] i_cfg_data;

    keyer_scoreboard keyer;
    int              quiet_cycles = 0;
    bit              calm = 1'b0;
    bit              long_hold = 1'b0;

    hex_morse_led_keyer i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_opcode         (i_opcode),
        .i_value          (i_value),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_led_on         (o_led_on),
        .o_phase          (o_phase),
        .o_digit_position (o_digit_position),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic send_word(input logic op, input logic [hml_pkg::VALUE_W-1:0] v);
        i_opcode = op;
        i_value  = v;
        i_valid  = 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [hml_pkg::CFG_IDX_W-1:0] idx,
                             input logic [hml_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        keyer.set_reg(idx, data);
    endtask

    task automatic set_timing(input logic [hml_pkg::HALF_W-1:0] h,
                              input logic [hml_pkg::GAP_W-1:0] g);
        i_valid = 1'b0;
        while (keyer.frames_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        write_reg(hml_pkg::CFG_HALF_UNIT, hml_pkg::CFG_DATA_W'(h));
        write_reg(hml_pkg::CFG_DIGIT_GAP, hml_pkg::CFG_DATA_W'(g));
    endtask

    // word accounting and watchdog count
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                keyer.check_word(t_led_frame'({o_led_on, o_phase, o_digit_position}));
            end
            if (i_valid && !o_stall) begin
                keyer.note_word(i_opcode, i_value);
            end
        end
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : watchdog
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("FAILED: results differ");
        $finish;
    end

    initial begin : receiver
        int n;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                i_stall = 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
                long_hold = 1'b0;
                i_stall   = 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 9);
                i_stall = 1'b1;
                repeat (n) @(negedge i_clk);
                i_stall = 1'b0;
            end
        end
    end

    initial begin : stimulus
        int n_words;
        keyer       = new();
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_opcode    = hml_pkg::OP_TICK;
        i_value     = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = hml_pkg::CFG_HALF_UNIT;
        i_cfg_data  = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // ticks while idle, full-range loads, reload while keying
        send_word(hml_pkg::OP_TICK, 16'hFFFF);
        send_word(hml_pkg::OP_TICK, 16'h0000);
        send_word(hml_pkg::OP_LOAD, 16'hFFFF);
        repeat (3) send_word(hml_pkg::OP_TICK, 16'h0000);
        send_word(hml_pkg::OP_LOAD, 16'h0000);
        repeat (2) send_word(hml_pkg::OP_TICK, 16'hFFFF);

        // zero lengths end each phase on its first tick, then wrap to digit 0
        set_timing(24'd0, 25'd0);
        send_word(hml_pkg::OP_LOAD, 16'hEEEE);
        repeat (14) send_word(hml_pkg::OP_TICK, 16'($urandom));

        for (int p = 0; p < 10; p++) begin
            case (p)
                0: set_timing(24'hFFFFFF, 25'h1FFFFFF);
                1: set_timing(24'd1, 25'd1);
                2: set_timing(24'd0, 25'h1FFFFFF);
                default: set_timing(24'($urandom_range(0, 4)), 25'($urandom_range(0, 8)));
            endcase
            calm = (p >= 8);
            if (p == 4) long_hold = 1'b1;
            n_words = (p < 3) ? 40 : 122;
            repeat (n_words) begin
                if (!calm && $urandom_range(0, 7) == 0) begin
                    i_valid  = 1'b0;
                    i_opcode = 1'($urandom);
                    i_value  = 16'($urandom);
                    repeat ($urandom_range(1, 9)) @(negedge i_clk);
                end
                send_word(($urandom_range(0, 47) == 0) ? hml_pkg::OP_LOAD : hml_pkg::OP_TICK,
                          16'($urandom));
            end
        end

        i_valid = 1'b0;
        while (keyer.frames_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (keyer.errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
